FILE: rtl/tick_delay_wakeup_queue_assert.svh
// Assertion macros used by the RTL of the tick delay wake-up queue.
// Each macro samples on the rising edge of clock and is disabled in reset.
`ifndef TICK_DELAY_WAKEUP_QUEUE_ASSERT_SVH
`define TICK_DELAY_WAKEUP_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDWQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDWQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tdwq_pkg.sv
`timescale 1ns / 1ps

package tdwq_pkg;

   localparam int QUEUE_DEPTH = 32;
   // Address of one physical slot, and a count that can hold the depth itself.
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_DELAY = 2'd1,
      OP_UNTIL = 2'd2,
      OP_TIME  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACK    = 2'd0,
      KIND_WAKE   = 2'd1,
      KIND_TIME   = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK_INC,
      S_TICK_CMP,
      S_REPLY,
      S_INS_START,
      S_INS_CMP,
      S_INS_PUT
   } state_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [7:0]  task_id;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic cnt_inc;
      logic rd_head;
      logic pop;
      logic ins_begin;
      logic ins_shift;
      logic ins_put;
      logic emit;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic [LW-1:0] occ;
      logic          occ_zero;
      logic          occ_full;
      logic          wake_hit;
      logic          shift_hit;
      logic          wpos_one;
      logic          out_free;
   } status_type;

   // Physical slot of the queue position offs, counted from the head.
   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                               input logic [LW-1:0] offs);
      logic [LW:0] sum;
      sum = {{(LW + 1 - AW){1'b0}}, head} + {1'b0, offs};
      if (sum >= (LW + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (LW + 1)'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

endpackage

FILE: rtl/tdwq_req_if.sv
`timescale 1ns / 1ps

interface tdwq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  task_id;
   logic [31:0] tick_value;

   modport source (output valid, output opcode, output task_id, output tick_value,
                   input ready);
   modport sink (input valid, input opcode, input task_id, input tick_value,
                 output ready);
endinterface

FILE: rtl/tdwq_rsp_if.sv
`timescale 1ns / 1ps

interface tdwq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  target_task;
   logic [31:0] current_time;
   logic        last;

   modport source (output valid, output kind, output target_task, output current_time,
                   output last, input ready);
   modport sink (input valid, input kind, input target_task, input current_time,
                 input last, output ready);
endinterface

FILE: rtl/tdwq_ctrl.sv
`timescale 1ns / 1ps

module tdwq_ctrl import tdwq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  op_type     req_opcode,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_opcode)
                  OP_TICK: state_in = S_TICK_INC;
                  OP_TIME: state_in = S_REPLY;
                  default: state_in = status.occ_full ? S_REPLY : S_INS_START;
               endcase
            end
         end
         S_TICK_INC: begin
            cmd.cnt_inc = 1'b1;
            cmd.rd_head = 1'b1;
            state_in    = S_TICK_CMP;
         end
         S_TICK_CMP: begin
            // The pending result goes out once the next entry is known.
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = !status.wake_hit;
               if (status.wake_hit) begin
                  cmd.pop = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_REPLY: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_INS_START: begin
            cmd.ins_begin = 1'b1;
            state_in      = status.occ_zero ? S_INS_PUT : S_INS_CMP;
         end
         S_INS_CMP: begin
            if (status.shift_hit) begin
               cmd.ins_shift = 1'b1;
               state_in      = status.wpos_one ? S_INS_PUT : S_INS_CMP;
            end else begin
               cmd.ins_put = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_INS_PUT: begin
            cmd.ins_put = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/tdwq_dp.sv
`timescale 1ns / 1ps

module tdwq_dp import tdwq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  op_type      req_opcode,
   input  logic [7:0]  req_task_id,
   input  logic [31:0] req_tick_value,
   input  logic        rsp_ready,
   output status_type  status,
   output logic        rsp_valid,
   output kind_type    rsp_kind,
   output logic [7:0]  rsp_target_task,
   output logic [31:0] rsp_current_time,
   output logic        rsp_last
);

   logic [31:0]   count_ff;
   logic [AW-1:0] head_ff;
   logic [LW-1:0] occ_ff;
   logic [LW-1:0] wpos_ff;
   logic [31:0]   dl_ff;
   kind_type      pend_kind_ff;
   logic [7:0]    pend_task_ff;
   logic          out_valid_ff;
   kind_type      out_kind_ff;
   logic [7:0]    out_task_ff;
   logic [31:0]   out_time_ff;
   logic          out_last_ff;

   entry_type     queue_mem [QUEUE_DEPTH];
   entry_type     rd_data_ff;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [LW-1:0] occ_prev;
   logic [LW-1:0] wpos_back2;
   logic          occ_zero;
   logic          out_free;

   assign occ_zero   = (occ_ff == '0);
   assign out_free   = !out_valid_ff || rsp_ready;
   assign occ_prev   = occ_zero ? '0 : occ_ff - 1'b1;
   assign wpos_back2 = (wpos_ff >= LW'(2)) ? wpos_ff - LW'(2) : '0;

   // Read and write ports of the queue store.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = head_ff;
      wr_en   = 1'b0;
      wr_addr = ring_addr(head_ff, wpos_ff);
      wr_data = rd_data_ff;
      if (cmd.rd_head) begin
         rd_en = 1'b1;
      end
      if (cmd.pop) begin
         rd_en   = 1'b1;
         rd_addr = ring_addr(head_ff, LW'(1));
      end
      if (cmd.ins_begin) begin
         rd_en   = 1'b1;
         rd_addr = ring_addr(head_ff, occ_prev);
      end
      if (cmd.ins_shift) begin
         rd_en   = 1'b1;
         rd_addr = ring_addr(head_ff, wpos_back2);
         wr_en   = 1'b1;
      end
      if (cmd.ins_put) begin
         wr_en   = 1'b1;
         wr_data = '{deadline: dl_ff, task_id: pend_task_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= queue_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + 32'd1;
         end
         if (cmd.pop) begin
            head_ff <= ring_addr(head_ff, LW'(1));
            occ_ff  <= occ_ff - 1'b1;
         end
         if (cmd.ins_put) begin
            occ_ff <= occ_ff + 1'b1;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dl_ff        <= (req_opcode == OP_DELAY) ? count_ff + req_tick_value
                                                  : req_tick_value;
         pend_task_ff <= req_task_id;
         case (req_opcode)
            OP_TICK: pend_kind_ff <= KIND_ACK;
            OP_TIME: pend_kind_ff <= KIND_TIME;
            default: pend_kind_ff <= KIND_REJECT;
         endcase
      end
      if (cmd.pop) begin
         pend_kind_ff <= KIND_WAKE;
         pend_task_ff <= rd_data_ff.task_id;
      end
      if (cmd.ins_begin) begin
         wpos_ff <= occ_ff;
      end
      if (cmd.ins_shift) begin
         wpos_ff <= wpos_ff - 1'b1;
      end
      if (cmd.emit) begin
         out_kind_ff <= pend_kind_ff;
         out_task_ff <= pend_task_ff;
         out_time_ff <= count_ff;
         out_last_ff <= cmd.emit_last;
      end
   end

   always_comb begin
      status.occ       = occ_ff;
      status.occ_zero  = occ_zero;
      status.occ_full  = (occ_ff == LW'(QUEUE_DEPTH));
      status.wake_hit  = !occ_zero && (rd_data_ff.deadline < count_ff);
      status.shift_hit = (rd_data_ff.deadline > dl_ff);
      status.wpos_one  = (wpos_ff == LW'(1));
      status.out_free  = out_free;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_target_task  = out_task_ff;
   assign rsp_current_time = out_time_ff;
   assign rsp_last         = out_last_ff;

endmodule

FILE: rtl/tick_delay_wakeup_queue.sv
`timescale 1ns / 1ps
// Tick counter with a deadline-ordered wake-up queue.
// Requests enter on req_chan (valid/ready): tick, relative delay, delay until an
// absolute tick, or read time. Results leave on rsp_chan (valid/ready); the
// final result of each request carries last.
// A read time request, or a delay into a full queue, gives one result, loaded in
// S_REPLY when the output is free, and the input is ready again as it appears.
// A tick gives its acknowledgement from S_TICK_CMP after S_TICK_INC, then one
// wake per cycle for each due task while the receiver does not stall.
// The wake loop reads one queue slot per cycle from the store while the output is free.
// A delay that is inserted gives no result; insertion walks the sorted queue from
// its tail, one slot per cycle.
// Only one request is in flight at a time; the input is ready again once the
// last result of the previous request sits in the output register, or once an insertion is written.
// When the receiver stalls, the output register holds its item and the wake
// loop waits without losing its place.
// Reset clears the tick count and empties the queue; no clearing pass runs over
// the queue store.
`include "tick_delay_wakeup_queue_assert.svh"

module tick_delay_wakeup_queue import tdwq_pkg::*; (
   input logic        clock,
   input logic        reset,
   tdwq_req_if.sink   req_chan,
   tdwq_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;
   op_type     req_op;
   kind_type   rsp_kind;
   logic       req_ready;

   assign req_op         = op_type'(req_chan.opcode);
   assign req_chan.ready = req_ready;

   // The controller sequences ticks, replies and insertions.
   tdwq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_op),
      .status     (status),
      .req_ready  (req_ready),
      .cmd        (cmd)
   );

   // The datapath holds the count, the queue store and the output register.
   tdwq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_opcode       (req_op),
      .req_task_id      (req_chan.task_id),
      .req_tick_value   (req_chan.tick_value),
      .rsp_ready        (rsp_chan.ready),
      .status           (status),
      .rsp_valid        (rsp_chan.valid),
      .rsp_kind         (rsp_kind),
      .rsp_target_task  (rsp_chan.target_task),
      .rsp_current_time (rsp_chan.current_time),
      .rsp_last         (rsp_chan.last)
   );

   assign rsp_chan.kind = rsp_kind;

   // An insertion grows the queue by exactly one entry.
   `TDWQ_ASSERT_NEXT(a_put_grows, cmd.ins_put, status.occ == $past(status.occ) + 1'b1, "insert did not grow the queue")
   // A full queue is never written.
   `TDWQ_ASSERT_NOW(a_no_overflow, cmd.ins_put, !status.occ_full, "insert into a full queue")
   // A result that is not the final one always comes with a wake.
   `TDWQ_ASSERT_NOW(a_more_follows, cmd.emit && !cmd.emit_last, cmd.pop, "non-final item without a wake")
   // A result is only loaded when the output register can take it.
   `TDWQ_ASSERT_NOW(a_emit_free, cmd.emit, status.out_free, "item loaded over a stalled item")

endmodule
